@@ design/h2r_pkg.sv @@
package h2r_pkg;

  // component width of every color field and range register
  localparam int CB = 8;

  // working widths
  localparam int HW    = CB + 3;      // six times a hue offset
  localparam int P_W   = 2 * CB;      // product of two components
  localparam int T_W   = 3 * CB;      // product of three components
  localparam int NUM_W = 3 * CB + 1;  // rounded dividend
  localparam int DEN_W = 2 * CB + 1;  // doubled divisor

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 1'b1;

  // reset values of the range registers
  localparam logic [CB-1:0] RANGE_START_RST = '0;
  localparam logic [CB-1:0] RANGE_END_RST   = CB'(255);

  // hue sectors, named by the colors at their start and end
  localparam logic [2:0] SECT_R_Y = 3'd0;
  localparam logic [2:0] SECT_Y_G = 3'd1;
  localparam logic [2:0] SECT_G_C = 3'd2;
  localparam logic [2:0] SECT_C_B = 3'd3;
  localparam logic [2:0] SECT_B_M = 3'd4;
  localparam logic [2:0] SECT_M_R = 3'd5;

  typedef struct packed {
    logic [CB-1:0] hue;
    logic [CB-1:0] saturation;
    logic [CB-1:0] brightness;
  } hsv_pix_t;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic          range_error;
  } rgb_pix_t;

  // values that ride alongside the divider
  typedef struct packed {
    logic          err;
    logic [2:0]    sector;
    logic [CB-1:0] vn;
  } side_t;

  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [NUM_W-1:0]  num_mid;
    logic [DEN_W-1:0]  den_mid;
    logic [NUM_W-1:0]  num_min;
    logic [DEN_W-1:0]  den_min;
  } div_req_t;

  typedef struct packed {
    logic          valid;
    side_t         side;
    logic [CB-1:0] q_mid;
    logic [CB-1:0] q_min;
  } div_rsp_t;

endpackage

@@ design/h2r_divpipe.sv @@
module h2r_divpipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  h2r_pkg::div_req_t req,
  output h2r_pkg::div_rsp_t rsp
);
  import h2r_pkg::*;

  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [NUM_W-1:0] rem_mid;
    logic [DEN_W-1:0] den_mid;
    logic [CB-1:0]    q_mid;
    logic [NUM_W-1:0] rem_min;
    logic [DEN_W-1:0] den_min;
    logic [CB-1:0]    q_min;
  } stage_t;

  stage_t stage_r [CB];

  // one quotient bit per stage, most significant first, two lanes side by side
  for (genvar i = 0; i < CB; i++) begin : g_step
    localparam int B = CB - 1 - i;
    stage_t           cur;
    stage_t           stage_nxt;
    logic [NUM_W-1:0] dsh_mid;
    logic [NUM_W-1:0] dsh_min;

    if (i == 0) begin : g_first
      always_comb begin
        cur.valid   = req.valid;
        cur.side    = req.side;
        cur.rem_mid = req.num_mid;
        cur.den_mid = req.den_mid;
        cur.q_mid   = '0;
        cur.rem_min = req.num_min;
        cur.den_min = req.den_min;
        cur.q_min   = '0;
      end
    end else begin : g_next
      assign cur = stage_r[i-1];
    end

    assign dsh_mid = NUM_W'(cur.den_mid) << B;
    assign dsh_min = NUM_W'(cur.den_min) << B;

    // restoring step on each lane
    always_comb begin
      stage_nxt = cur;
      if (cur.rem_mid >= dsh_mid) begin
        stage_nxt.rem_mid  = cur.rem_mid - dsh_mid;
        stage_nxt.q_mid[B] = 1'b1;
      end
      if (cur.rem_min >= dsh_min) begin
        stage_nxt.rem_min  = cur.rem_min - dsh_min;
        stage_nxt.q_min[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[i].valid <= 1'b0;
      end else if (adv) begin
        stage_r[i] <= stage_nxt;
      end
    end
  end

  // last stage holds the finished quotients
  always_comb begin
    rsp.valid = stage_r[CB-1].valid;
    rsp.side  = stage_r[CB-1].side;
    rsp.q_mid = stage_r[CB-1].q_mid;
    rsp.q_min = stage_r[CB-1].q_min;
  end

endmodule

@@ design/hsv_to_rgb_ranged.sv @@
// channel  direction  handshake                payload
// in       input      in_valid / in_ready      in_data   (hue, saturation, brightness)
// out      output     out_valid / out_ready    out_data  (red, green, blue, range_error)
// cfg      input      cfg_we, no wait          cfg_index, cfg_wdata
//
// one item per clock while out_ready does not stall; the path runs through five
// arithmetic stages, the divider with one quotient bit per stage, and the
// output register.
// rst_n is synchronous: it clears all valid bits and loads range 0 to 255.
// a stall on out_ready freezes every stage at once; in_ready is high whenever
// the output register is empty or being taken.
module hsv_to_rgb_ranged (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  h2r_pkg::hsv_pix_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output h2r_pkg::rgb_pix_t                  out_data,
  input  logic                               cfg_we,
  input  logic [h2r_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [h2r_pkg::CB-1:0]             cfg_wdata
);
  import h2r_pkg::*;

  // clamp to the range and take the offset from its start
  function automatic logic [CB-1:0] clamp_norm(input logic [CB-1:0] x,
                                               input logic [CB-1:0] lo,
                                               input logic [CB-1:0] hi);
    logic [CB-1:0] res;
    if (x < lo) res = '0;
    else if (x > hi) res = hi - lo;
    else res = x - lo;
    return res;
  endfunction

  // add the range start back and clamp to the range end
  function automatic logic [CB-1:0] fit(input logic [CB-1:0] x,
                                        input logic [CB-1:0] lo,
                                        input logic [CB-1:0] hi);
    logic [CB:0]   sum;
    logic [CB-1:0] res;
    sum = {1'b0, x} + {1'b0, lo};
    if (sum > {1'b0, hi}) res = hi;
    else res = sum[CB-1:0];
    return res;
  endfunction

  logic [CB-1:0] range_start_r;
  logic [CB-1:0] range_end_r;
  logic          adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= RANGE_START_RST;
      range_end_r   <= RANGE_END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_START: range_start_r <= cfg_wdata;
        CFG_RANGE_END:   range_end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output register can take a new item
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: range check, clamp and normalize
  logic          s1_valid_r, s1_err_r;
  logic [CB-1:0] s1_d_r, s1_hn_r, s1_sn_r, s1_vn_r;
  logic [CB-1:0] s1_d_nxt, s1_hn_nxt;

  always_comb begin
    s1_d_nxt  = range_end_r - range_start_r;
    s1_hn_nxt = clamp_norm(in_data.hue, range_start_r, range_end_r);
    // hue at the range end is a full turn
    if (s1_hn_nxt == s1_d_nxt) s1_hn_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s1_err_r   <= (range_end_r <= range_start_r);
      s1_d_r     <= s1_d_nxt;
      s1_hn_r    <= s1_hn_nxt;
      s1_sn_r    <= clamp_norm(in_data.saturation, range_start_r, range_end_r);
      s1_vn_r    <= clamp_norm(in_data.brightness, range_start_r, range_end_r);
    end
  end

  // stage 2: sector and fraction of 6*hue over the span
  logic          s2_valid_r, s2_err_r;
  logic [CB-1:0] s2_d_r, s2_sn_r, s2_vn_r, s2_dms_r, s2_g_r;
  logic [2:0]    s2_sect_r;
  logic [HW-1:0] t6, d4, d2x, d1;
  logic [2:0]    s2_sect_nxt;
  logic [CB-1:0] s2_g_nxt;

  always_comb begin
    t6  = HW'(s1_hn_r) * HW'(6);
    d4  = HW'(s1_d_r) << 2;
    d2x = HW'(s1_d_r) << 1;
    d1  = HW'(s1_d_r);
    s2_sect_nxt = '0;
    if (t6 >= d4) begin
      t6 = t6 - d4;
      s2_sect_nxt[2] = 1'b1;
    end
    if (t6 >= d2x) begin
      t6 = t6 - d2x;
      s2_sect_nxt[1] = 1'b1;
    end
    if (t6 >= d1) begin
      t6 = t6 - d1;
      s2_sect_nxt[0] = 1'b1;
    end
    // falling edge of the ramp in odd sectors
    if (s2_sect_nxt[0]) s2_g_nxt = s1_d_r - t6[CB-1:0];
    else s2_g_nxt = t6[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
      s2_err_r   <= s1_err_r;
      s2_d_r     <= s1_d_r;
      s2_sn_r    <= s1_sn_r;
      s2_vn_r    <= s1_vn_r;
      s2_dms_r   <= s1_d_r - s1_sn_r;
      s2_g_r     <= s2_g_nxt;
      s2_sect_r  <= s2_sect_nxt;
    end
  end

  // stage 3: first products
  logic           s3_valid_r, s3_err_r;
  logic [CB-1:0]  s3_d_r, s3_vn_r, s3_g_r;
  logic [2:0]     s3_sect_r;
  logic [P_W-1:0] s3_vmin_r, s3_vs_r, s3_dd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
      s3_err_r   <= s2_err_r;
      s3_d_r     <= s2_d_r;
      s3_vn_r    <= s2_vn_r;
      s3_g_r     <= s2_g_r;
      s3_sect_r  <= s2_sect_r;
      s3_vmin_r  <= P_W'(s2_vn_r) * P_W'(s2_dms_r);
      s3_vs_r    <= P_W'(s2_vn_r) * P_W'(s2_sn_r);
      s3_dd_r    <= P_W'(s2_d_r) * P_W'(s2_d_r);
    end
  end

  // stage 4: numerators over the squared span
  logic           s4_valid_r, s4_err_r;
  logic [CB-1:0]  s4_d_r, s4_vn_r;
  logic [2:0]     s4_sect_r;
  logic [P_W-1:0] s4_vmin_r, s4_dd_r;
  logic [T_W-1:0] s4_a_r, s4_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
      s4_err_r   <= s3_err_r;
      s4_d_r     <= s3_d_r;
      s4_vn_r    <= s3_vn_r;
      s4_sect_r  <= s3_sect_r;
      s4_vmin_r  <= s3_vmin_r;
      s4_dd_r    <= s3_dd_r;
      s4_a_r     <= T_W'(s3_vmin_r) * T_W'(s3_d_r);
      s4_b_r     <= T_W'(s3_vs_r) * T_W'(s3_g_r);
    end
  end

  // stage 5: dividends with the half-divisor added for rounding
  div_req_t         div_req_r;
  div_req_t         div_req_nxt;
  div_rsp_t         div_rsp;
  logic [NUM_W-1:0] sum_ab;

  always_comb begin
    sum_ab                 = NUM_W'(s4_a_r) + NUM_W'(s4_b_r);
    div_req_nxt.valid      = s4_valid_r;
    div_req_nxt.side.err   = s4_err_r;
    div_req_nxt.side.sector = s4_sect_r;
    div_req_nxt.side.vn    = s4_vn_r;
    div_req_nxt.num_mid    = {sum_ab[NUM_W-2:0], 1'b0} + NUM_W'(s4_dd_r);
    div_req_nxt.den_mid    = {s4_dd_r, 1'b0};
    div_req_nxt.num_min    = NUM_W'({s4_vmin_r, 1'b0}) + NUM_W'(s4_d_r);
    div_req_nxt.den_min    = DEN_W'({s4_d_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_req_r.valid <= 1'b0;
    end else if (adv) begin
      div_req_r <= div_req_nxt;
    end
  end

  h2r_divpipe u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  // output stage: place max, mid and min by sector, shift back into the range; error items go out as zeros
  logic          out_valid_r;
  rgb_pix_t      out_data_r;
  rgb_pix_t      out_data_nxt;
  logic [CB-1:0] r_rel, g_rel, b_rel;

  always_comb begin
    case (div_rsp.side.sector)
      SECT_R_Y: begin
        r_rel = div_rsp.side.vn; g_rel = div_rsp.q_mid; b_rel = div_rsp.q_min;
      end
      SECT_Y_G: begin
        r_rel = div_rsp.q_mid; g_rel = div_rsp.side.vn; b_rel = div_rsp.q_min;
      end
      SECT_G_C: begin
        r_rel = div_rsp.q_min; g_rel = div_rsp.side.vn; b_rel = div_rsp.q_mid;
      end
      SECT_C_B: begin
        r_rel = div_rsp.q_min; g_rel = div_rsp.q_mid; b_rel = div_rsp.side.vn;
      end
      SECT_B_M: begin
        r_rel = div_rsp.q_mid; g_rel = div_rsp.q_min; b_rel = div_rsp.side.vn;
      end
      default: begin
        r_rel = div_rsp.side.vn; g_rel = div_rsp.q_min; b_rel = div_rsp.q_mid;
      end
    endcase
    if (div_rsp.side.err) begin
      out_data_nxt.red         = '0;
      out_data_nxt.green       = '0;
      out_data_nxt.blue        = '0;
      out_data_nxt.range_error = 1'b1;
    end else begin
      out_data_nxt.red         = fit(r_rel, range_start_r, range_end_r);
      out_data_nxt.green       = fit(g_rel, range_start_r, range_end_r);
      out_data_nxt.blue        = fit(b_rel, range_start_r, range_end_r);
      out_data_nxt.range_error = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_rsp.valid;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/h2r_checker.sv @@
module h2r_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input h2r_pkg::hsv_pix_t             in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input h2r_pkg::rgb_pix_t             out_data
);
  import h2r_pkg::*;

  // an empty output register never holds back the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  // an offered item stays put until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed or dropped while waiting");

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // an error item carries zero components
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |->
      out_data.red == '0 && out_data.green == '0 && out_data.blue == '0)
    else $error("range error item with nonzero components");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind hsv_to_rgb_ranged h2r_checker u_h2r_checker (.*);

@@ bench/hsv_to_rgb_ranged_tb.sv @@
module hsv_to_rgb_ranged_tb;
  import h2r_pkg::*;

  // cycles without any accepted item before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // cycles allowed after the last result for stray outputs to show up
  localparam int DRAIN_CYCLES = 6 + CB + 6;
  // length of the one long receiver hold-off
  localparam int LONG_HOLD = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  hsv_pix_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rgb_pix_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RANGE_START;
  logic [CB-1:0]        cfg_wdata = '0;

  // local copy of the range registers
  logic [CB-1:0] range_lo = RANGE_START_RST;
  logic [CB-1:0] range_hi = RANGE_END_RST;

  hsv_pix_t pending_pix[$];
  rgb_pix_t rgb_expected[$];

  int   errors = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;
  logic in_fire = 1'b0;

  hsv_to_rgb_ranged dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // clamp an input component into the current range
  function automatic logic [31:0] clamp_comp(logic [CB-1:0] x);
    if (x < range_lo) return 32'(range_lo);
    if (x > range_hi) return 32'(range_hi);
    return 32'(x);
  endfunction

  // round num/den to nearest, ties up, then shift back into the range
  function automatic logic [CB-1:0] scale_back(logic [31:0] num, logic [31:0] den);
    logic [31:0] q;
    q = (2 * num + den) / (2 * den) + 32'(range_lo);
    if (q > 32'(range_hi)) q = 32'(range_hi);
    return q[CB-1:0];
  endfunction

  // exact hsv to rgb conversion over the configured range
  function automatic rgb_pix_t convert_pix(hsv_pix_t px);
    rgb_pix_t    o;
    logic [31:0] dd, d2, hv, sv, vv, fr, g;
    logic [31:0] vmax, vmin, vmid;
    logic [2:0]  sect;
    logic [CB-1:0] cmax, cmid, cmin;
    o = '0;
    // empty or inverted range
    if (range_hi <= range_lo) begin
      o.range_error = 1'b1;
      return o;
    end
    dd = 32'(range_hi) - 32'(range_lo);
    d2 = dd * dd;
    hv = clamp_comp(px.hue) - 32'(range_lo);
    sv = clamp_comp(px.saturation) - 32'(range_lo);
    vv = clamp_comp(px.brightness) - 32'(range_lo);
    // hue at the range end is a full turn
    if (hv == dd) hv = 0;
    sect = 3'((6 * hv) / dd);
    if (sect > SECT_M_R) sect = SECT_M_R;
    fr = 6 * hv - 32'(sect) * dd;
    g = sect[0] ? (dd - fr) : fr;
    vmax = vv * d2;
    vmin = vv * dd * (dd - sv);
    vmid = vmin + vv * sv * g;
    cmax = scale_back(vmax, d2);
    cmid = scale_back(vmid, d2);
    cmin = scale_back(vmin, d2);
    case (sect)
      SECT_R_Y: begin o.red = cmax; o.green = cmid; o.blue = cmin; end
      SECT_Y_G: begin o.red = cmid; o.green = cmax; o.blue = cmin; end
      SECT_G_C: begin o.red = cmin; o.green = cmax; o.blue = cmid; end
      SECT_C_B: begin o.red = cmin; o.green = cmid; o.blue = cmax; end
      SECT_B_M: begin o.red = cmid; o.green = cmin; o.blue = cmax; end
      default: begin o.red = cmax; o.green = cmin; o.blue = cmid; end
    endcase
    return o;
  endfunction

  // random component, mostly inside the range, some at the bounds or anywhere
  function automatic logic [CB-1:0] rand_comp(int lo, int hi);
    int k;
    k = $urandom_range(0, 9);
    if (hi < lo || k >= 8) return CB'($urandom_range(0, 255));
    if (k == 7) return CB'($urandom_range(0, 1) ? lo : hi);
    return CB'($urandom_range(hi, lo));
  endfunction

  task automatic add_pix(logic [CB-1:0] h, logic [CB-1:0] s, logic [CB-1:0] v);
    hsv_pix_t px;
    px.hue = h;
    px.saturation = s;
    px.brightness = v;
    pending_pix.push_back(px);
  endtask

  // wait until every queued item has gone through and come back
  task automatic wait_drained();
    while (pending_pix.size() != 0 || in_valid || rgb_expected.size() != 0)
      @(posedge clk);
  endtask

  // write both range registers while the block is idle
  task automatic set_range(logic [CB-1:0] lo, logic [CB-1:0] hi);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RANGE_START;
    cfg_wdata <= lo;
    range_lo = lo;
    @(negedge clk);
    cfg_index <= CFG_RANGE_END;
    cfg_wdata <= hi;
    range_hi = hi;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_field(string name, logic [CB-1:0] want, logic [CB-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_pix.size() != 0) begin
        in_data <= pending_pix.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes mode, plus one long hold-off
  // started while plenty of items are still waiting to be sent
  int  ready_cyc = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    ready_cyc++;
    if (!hold_done && results_seen >= 150 && pending_pix.size() >= 30) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((ready_cyc / 97) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (ready_cyc % 4 == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: predict on input accept, compare on output accept, watchdog
  always @(posedge clk) begin : monitor
    rgb_pix_t want_pix;
    logic     moved;
    if (!rst_n) begin
      in_fire <= 1'b0;
      idle_cycles <= 0;
    end else begin
      moved = (in_valid && in_ready) || (out_valid && out_ready);
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready)
        rgb_expected.push_back(convert_pix(in_data));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (rgb_expected.size() == 0) begin
          $error("result with no item outstanding: %h", out_data);
          errors++;
        end else begin
          want_pix = rgb_expected.pop_front();
          report_field("red", want_pix.red, out_data.red);
          report_field("green", want_pix.green, out_data.green);
          report_field("blue", want_pix.blue, out_data.blue);
          report_field("range_error", CB'(want_pix.range_error), CB'(out_data.range_error));
        end
      end
      if (moved) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus sequence
  initial begin : stim
    int lo_tab[10];
    int hi_tab[10];
    int lo_v, hi_v;
    lo_tab = '{0, 0, 254, 0, 16, 255, 128, 100, 0, 200};
    hi_tab = '{255, 1, 255, 128, 235, 0, 255, 101, 255, 200};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset range: corners, sector edges, gray and black
    add_pix(0, 0, 0);
    add_pix(255, 255, 255);
    add_pix(0, 255, 255);
    add_pix(43, 255, 255);
    add_pix(85, 255, 255);
    add_pix(128, 255, 255);
    add_pix(170, 255, 255);
    add_pix(213, 255, 255);
    add_pix(42, 255, 255);
    add_pix(100, 0, 200);
    add_pix(100, 200, 0);
    add_pix(1, 254, 127);
    add_pix(127, 128, 1);
    add_pix(254, 1, 255);
    wait_drained();

    // narrow range: inputs below and above it, hue at the end
    set_range(50, 200);
    add_pix(10, 20, 30);
    add_pix(250, 240, 230);
    add_pix(200, 200, 200);
    add_pix(50, 50, 50);
    add_pix(125, 125, 125);
    wait_drained();

    // inverted range then empty range
    set_range(10, 5);
    add_pix(0, 0, 0);
    add_pix(255, 255, 255);
    wait_drained();
    set_range(7, 7);
    add_pix(7, 7, 7);
    wait_drained();

    // span of one
    set_range(0, 1);
    add_pix(0, 1, 1);
    add_pix(1, 1, 1);
    add_pix(2, 0, 1);
    wait_drained();

    // random phases over a spread of ranges
    for (int p = 0; p < 12; p++) begin
      if (p < 10) begin
        lo_v = lo_tab[p];
        hi_v = hi_tab[p];
      end else begin
        lo_v = $urandom_range(0, 255);
        hi_v = $urandom_range(0, 255);
      end
      set_range(CB'(lo_v), CB'(hi_v));
      for (int n = 0; n < 46; n++)
        add_pix(rand_comp(lo_v, hi_v), rand_comp(lo_v, hi_v), rand_comp(lo_v, hi_v));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && rgb_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/h2r_pkg.sv
design/h2r_divpipe.sv
design/hsv_to_rgb_ranged.sv
design/h2r_checker.sv
bench/hsv_to_rgb_ranged_tb.sv
